/* rtl/rrf_pkg.sv */
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared widths, types and register indexes for the rounded rectangle fill
// scanner.
// ----------------------------------------------------------------------------
package rrf_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int PIX_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [RAD_BITS-1:0]   radius_t;
  typedef logic [PIX_BITS-1:0]   pix_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOX_LEFT      = 3'd0,
    REG_BOX_TOP       = 3'd1,
    REG_BOX_WIDTH     = 3'd2,
    REG_BOX_HEIGHT    = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5
  } cfg_reg_t;

endpackage

/* rtl/rrf_ifs.sv */
// ----------------------------------------------------------------------------
// rrf channel interfaces
// Valid/ready channels for scan steps in and pixels out.
// ----------------------------------------------------------------------------
interface rrf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rrf_out_if;
  logic                      valid;
  logic                      ready;
  logic [rrf_pkg::PIX_BITS-1:0]   pixel_x;
  logic [rrf_pkg::PIX_BITS-1:0]   pixel_y;
  logic                      write_enable;
  logic [rrf_pkg::COLOR_BITS-1:0] pixel_color;
  logic                      last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output write_enable,
                  output pixel_color, output last_pixel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input write_enable,
                  input pixel_color, input last_pixel, output ready);
endinterface

/* rtl/rounded_rect_fill_scan_unit.sv */
// ----------------------------------------------------------------------------
// rounded_rect_fill_scan_unit
// Walks the bounding box of a filled rounded rectangle in raster order and
// gives one pixel (coordinates, write flag, colour, last flag) per step.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        handshake
//  in_chan   in   restart                                        valid/ready
//  out_chan  out  pixel_x, pixel_y, write_enable, pixel_color,   valid/ready
//                 last_pixel
//  cfg_*     in   cfg_index, cfg_data                            cfg_we
//
// The scan position is worked out and advanced at acceptance into the item
// register; the corner distance test (three squarers, one add and compare)
// sits between the item register and the result register. One item per
// clock sustained while out_chan.ready stays high.
// A held pixel stops the result register; the item register takes one more
// item, then in_chan.ready falls. Reset clears the scan position, the
// configuration and the valid flags.
// ----------------------------------------------------------------------------
module rounded_rect_fill_scan_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  rrf_pkg::cfg_reg_t                 cfg_index,
  input  logic [rrf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  rrf_in_if.sink                            in_chan,
  rrf_out_if.source                         out_chan
);
  import rrf_pkg::*;

  // configuration
  coord_t  box_left_r, box_top_r, box_width_r, box_height_r;
  radius_t corner_radius_r;
  color_t  fill_color_r;

  // scan position of the next pixel
  coord_t scan_col_r, scan_row_r;

  // item register
  logic   s1_valid_r;
  coord_t s1_col_r, s1_row_r;
  logic   s1_empty_r, s1_last_r;

  // result register
  logic   out_valid_r;
  pix_t   out_x_r, out_y_r;
  logic   out_we_r, out_last_r;
  color_t out_color_r;

  logic in_acc, s1_move, out_load;

  assign out_load = !out_valid_r || out_chan.ready;
  assign s1_move  = s1_valid_r && out_load;
  assign in_chan.ready = !s1_valid_r || out_load;
  assign in_acc   = in_chan.valid && in_chan.ready;

  // ---------------- position step ----------------
  logic                box_empty, pos_oob, cur_last;
  coord_t              base_col, base_row, cur_col, cur_row;
  coord_t              scan_col_nxt, scan_row_nxt;
  logic [COORD_BITS:0] col_inc, row_inc;

  always_comb begin
    box_empty = (box_width_r == '0) || (box_height_r == '0);
    base_col  = in_chan.restart ? '0 : scan_col_r;
    base_row  = in_chan.restart ? '0 : scan_row_r;
    pos_oob   = (base_col >= box_width_r) || (base_row >= box_height_r);
    cur_col   = (box_empty || pos_oob) ? '0 : base_col;
    cur_row   = (box_empty || pos_oob) ? '0 : base_row;
    cur_last  = box_empty ||
                ((cur_col == box_width_r - 1'b1) && (cur_row == box_height_r - 1'b1));
    col_inc   = {1'b0, cur_col} + 1'b1;
    row_inc   = {1'b0, cur_row} + 1'b1;
    if (box_empty) begin
      scan_col_nxt = '0;
      scan_row_nxt = '0;
    end else if (col_inc < {1'b0, box_width_r}) begin
      scan_col_nxt = col_inc[COORD_BITS-1:0];
      scan_row_nxt = cur_row;
    end else begin
      scan_col_nxt = '0;
      scan_row_nxt = (row_inc < {1'b0, box_height_r}) ? row_inc[COORD_BITS-1:0] : '0;
    end
  end

  // ---------------- coverage test ----------------
  radius_t                rad, half_w, half_h, rad_w, dx, dy;
  coord_t                 edge_x, edge_y, dx_full, dy_full;
  logic                   in_band_x, in_band_y, in_corner;
  logic [2*RAD_BITS-1:0]  dx2, dy2, rad2;
  logic [2*RAD_BITS:0]    dist2;

  always_comb begin
    half_w    = box_width_r[COORD_BITS-1:1];
    half_h    = box_height_r[COORD_BITS-1:1];
    rad_w     = (corner_radius_r > half_w) ? half_w : corner_radius_r;
    rad       = (rad_w > half_h) ? half_h : rad_w;
    edge_x    = box_width_r  - {1'b0, rad};
    edge_y    = box_height_r - {1'b0, rad};
    in_band_x = (s1_col_r >= {1'b0, rad}) && (s1_col_r < edge_x);
    in_band_y = (s1_row_r >= {1'b0, rad}) && (s1_row_r < edge_y);
    // right and bottom offsets are one pixel short of the left and top ones
    dx_full   = (s1_col_r < {1'b0, rad}) ? ({1'b0, rad} - s1_col_r) : (s1_col_r - edge_x);
    dy_full   = (s1_row_r < {1'b0, rad}) ? ({1'b0, rad} - s1_row_r) : (s1_row_r - edge_y);
    dx        = dx_full[RAD_BITS-1:0];
    dy        = dy_full[RAD_BITS-1:0];
    dx2       = dx * dx;
    dy2       = dy * dy;
    rad2      = rad * rad;
    dist2     = {1'b0, dx2} + {1'b0, dy2};
    in_corner = dist2 <= {1'b0, rad2};
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r      <= '0;
      box_top_r       <= '0;
      box_width_r     <= '0;
      box_height_r    <= '0;
      corner_radius_r <= '0;
      fill_color_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_LEFT:      box_left_r      <= cfg_data[COORD_BITS-1:0];
        REG_BOX_TOP:       box_top_r       <= cfg_data[COORD_BITS-1:0];
        REG_BOX_WIDTH:     box_width_r     <= cfg_data[COORD_BITS-1:0];
        REG_BOX_HEIGHT:    box_height_r    <= cfg_data[COORD_BITS-1:0];
        REG_CORNER_RADIUS: corner_radius_r <= cfg_data[RAD_BITS-1:0];
        REG_FILL_COLOR:    fill_color_r    <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r  <= '0;
      scan_row_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        scan_col_r <= scan_col_nxt;
        scan_row_r <= scan_row_nxt;
      end
      if (in_chan.ready) s1_valid_r <= in_chan.valid;
      if (out_load) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r   <= cur_col;
      s1_row_r   <= cur_row;
      s1_empty_r <= box_empty;
      s1_last_r  <= cur_last;
    end
    if (s1_move) begin
      out_x_r     <= {1'b0, box_left_r} + {1'b0, s1_col_r};
      out_y_r     <= {1'b0, box_top_r}  + {1'b0, s1_row_r};
      out_we_r    <= !s1_empty_r && (in_band_x || in_band_y || in_corner);
      out_color_r <= fill_color_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_x      = out_x_r;
  assign out_chan.pixel_y      = out_y_r;
  assign out_chan.write_enable = out_we_r;
  assign out_chan.pixel_color  = out_color_r;
  assign out_chan.last_pixel   = out_last_r;

  // ---------------- assertions ----------------
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item did not reach the item register");

  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (box_width_r == '0 || box_height_r == '0))
      |-> (!out_we_r && out_last_r))
    else $error("empty box gave a write or missed the last flag");

  a_scan_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cur_last) |=> (scan_col_r == '0 && scan_row_r == '0))
    else $error("scan position did not wrap after the last pixel");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_row_r)))
    else $error("item register changed while stalled");

endmodule

/* sim/rrf_scan_checker.sv */
// ----------------------------------------------------------------------------
// rrf_scan_checker
// Watches the configuration port and both channels of the rounded rectangle
// fill scanner, keeps its own copy of the registers and scan position, works
// out the pixel due for every accepted item and compares each pixel given
// against the oldest one due.
// ----------------------------------------------------------------------------
module rrf_scan_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  rrf_pkg::cfg_reg_t                 cfg_index,
  input  logic [rrf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  rrf_in_if                                 in_mon,
  rrf_out_if                                out_mon,
  output int                                fail_count,
  output int                                pixels_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrf_pkg::*;

  typedef struct packed {
    pix_t   x;
    pix_t   y;
    logic   we;
    color_t color;
    logic   last;
  } fill_pixel_t;

  coord_t  left_q, top_q, width_q, height_q;
  radius_t radius_q;
  color_t  color_q;
  int unsigned col_q, row_q;

  fill_pixel_t due_q[$];

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    fail_count++;
  endtask

  // true when the local pixel lies inside the rounded outline
  function automatic logic in_fill(int unsigned c, int unsigned r);
    int unsigned rad, w, h, dx, dy;
    longint unsigned d2, r2;
    rad = radius_q;
    w   = width_q;
    h   = height_q;
    if (rad > w / 2) rad = w / 2;
    if (rad > h / 2) rad = h / 2;
    if (c >= rad && c < w - rad) return 1'b1;
    if (r >= rad && r < h - rad) return 1'b1;
    // right and bottom offsets are measured from w-rad / h-rad, one short
    dx = (c < rad) ? rad - c : c - (w - rad);
    dy = (r < rad) ? rad - r : r - (h - rad);
    d2 = longint'(dx) * dx + longint'(dy) * dy;
    r2 = longint'(rad) * rad;
    return d2 <= r2;
  endfunction

  function automatic fill_pixel_t scan_step(logic restart);
    fill_pixel_t p;
    p.color = color_q;
    if (restart) begin
      col_q = 0;
      row_q = 0;
    end
    if (width_q == '0 || height_q == '0) begin
      col_q  = 0;
      row_q  = 0;
      p.x    = pix_t'(left_q);
      p.y    = pix_t'(top_q);
      p.we   = 1'b0;
      p.last = 1'b1;
      return p;
    end
    // box shrunk under a stored position: start again at the corner
    if (col_q >= width_q || row_q >= height_q) begin
      col_q = 0;
      row_q = 0;
    end
    p.x    = pix_t'(left_q) + pix_t'(col_q);
    p.y    = pix_t'(top_q) + pix_t'(row_q);
    p.we   = in_fill(col_q, row_q);
    p.last = (col_q == width_q - 1) && (row_q == height_q - 1);
    if (col_q + 1 < width_q) begin
      col_q = col_q + 1;
    end else begin
      col_q = 0;
      row_q = (row_q + 1 < height_q) ? row_q + 1 : 0;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    fill_pixel_t want;
    if (!rst_n) begin
      due_q.delete();
      left_q   = '0;
      top_q    = '0;
      width_q  = '0;
      height_q = '0;
      radius_q = '0;
      color_q  = '0;
      col_q    = 0;
      row_q    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("unexpected pixel x", '0, out_mon.pixel_x);
        end else begin
          want = due_q.pop_front();
          if (out_mon.pixel_x !== want.x)
            report_mismatch("pixel_x", want.x, out_mon.pixel_x);
          if (out_mon.pixel_y !== want.y)
            report_mismatch("pixel_y", want.y, out_mon.pixel_y);
          if (out_mon.write_enable !== want.we)
            report_mismatch("write_enable", want.we, out_mon.write_enable);
          if (out_mon.pixel_color !== want.color)
            report_mismatch("pixel_color", want.color, out_mon.pixel_color);
          if (out_mon.last_pixel !== want.last)
            report_mismatch("last_pixel", want.last, out_mon.last_pixel);
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_q.push_back(scan_step(in_mon.restart));
      if (cfg_we) begin
        case (cfg_index)
          REG_BOX_LEFT:      left_q   = cfg_data[COORD_BITS-1:0];
          REG_BOX_TOP:       top_q    = cfg_data[COORD_BITS-1:0];
          REG_BOX_WIDTH:     width_q  = cfg_data[COORD_BITS-1:0];
          REG_BOX_HEIGHT:    height_q = cfg_data[COORD_BITS-1:0];
          REG_CORNER_RADIUS: radius_q = cfg_data[RAD_BITS-1:0];
          REG_FILL_COLOR:    color_q  = cfg_data[COLOR_BITS-1:0];
          default: ;
        endcase
      end
    end
    pixels_due = due_q.size();
  end

  initial begin
    fail_count = 0;
    pixels_due = 0;
  end

endmodule

/* sim/tb_rounded_rect_fill_scan_unit.sv */
// ----------------------------------------------------------------------------
// tb_rounded_rect_fill_scan_unit
// Drives scan steps and register settings into the rounded rectangle fill
// scanner: a directed run over empty, single-pixel, full-size and shrinking
// boxes, then random boxes mostly small, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_rounded_rect_fill_scan_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rrf_pkg::*;

  localparam int STEP_TARGET = 550;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_reg_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fail_count;
  int                       pixels_due;
  int                       steps_sent;
  bit                       steady;

  rrf_in_if  in_chan ();
  rrf_out_if out_chan ();

  rounded_rect_fill_scan_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  rrf_scan_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pixels_due (pixels_due)
  );

  always #4 clk = ~clk;

  function automatic int draw_gap();
    if (steady) return 0;
    return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 18) : 0;
  endfunction

  // called just after a falling edge; leaves we high for a following write
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  // upper bits of each coordinate and radius write carry junk that the block must drop
  task automatic set_box(logic [5:0] sel, coord_t left, coord_t top, coord_t w,
                         coord_t h, radius_t rad, color_t color);
    logic [31:0] junk;
    junk = $urandom();
    if (sel[REG_BOX_LEFT])      write_reg(REG_BOX_LEFT, {junk[31:COORD_BITS], left});
    if (sel[REG_BOX_TOP])       write_reg(REG_BOX_TOP, {junk[31:COORD_BITS], top});
    if (sel[REG_BOX_WIDTH])     write_reg(REG_BOX_WIDTH, {junk[31:COORD_BITS], w});
    if (sel[REG_BOX_HEIGHT])    write_reg(REG_BOX_HEIGHT, {junk[31:COORD_BITS], h});
    if (sel[REG_CORNER_RADIUS]) write_reg(REG_CORNER_RADIUS, {junk[31:RAD_BITS], rad});
    if (sel[REG_FILL_COLOR])    write_reg(REG_FILL_COLOR, color);
    cfg_we = 1'b0;
  endtask

  // called just after a falling edge, returns just after a falling edge once the step is taken
  task automatic send_step(logic restart);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid   = 1'b1;
    in_chan.restart = restart;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    steps_sent++;
  endtask

  task automatic send_run(int n, logic first_restart);
    for (int i = 0; i < n; i++)
      send_step(i == 0 ? first_restart : ($urandom_range(0, 29) == 0));
  endtask

  // registers change only once every pixel due has come out
  task automatic settle();
    in_chan.valid = 1'b0;
    while (pixels_due != 0) @(negedge clk);
    steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic coord_t pick_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return coord_t'($urandom_range(0, 4095));
      2:       return '1;
      default: return coord_t'($urandom_range(1, 14));
    endcase
  endfunction

  function automatic radius_t pick_radius();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return radius_t'($urandom_range(0, 8));
      2:       return '1;
      3:       return radius_t'($urandom_range(0, 2047));
      default: return radius_t'($urandom_range(1, 7));
    endcase
  endfunction

  function automatic coord_t pick_origin();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    coord_t  w, h;
    int      area, n;
    bit      first;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_BOX_LEFT;
    cfg_data        = '0;
    in_chan.valid   = 1'b0;
    in_chan.restart = 1'b0;
    steps_sent      = 0;
    steady          = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers still at reset: empty box
    send_step(1'b0);
    send_step(1'b1);
    settle();
    // largest box and radius at the far corner of the coordinate space
    set_box('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
    send_step(1'b1);
    send_run(3, 1'b0);
    settle();
    // single pixel: every step is the last one
    set_box('1, '0, '0, 12'd1, 12'd1, '1, 32'h0);
    send_run(3, 1'b0);
    settle();
    // rounded box scanned into the second row
    set_box('1, 12'd10, 12'd20, 12'd6, 12'd5, 11'd3, 32'h1234_5678);
    send_run(10, 1'b1);
    settle();
    // shrink under the stored position without restart
    set_box(6'b00_1100, '0, '0, 12'd3, 12'd2, '0, '0);
    send_run(3, 1'b0);
    settle();
    // zero width, nonzero height
    set_box(6'b00_1100, '0, '0, '0, 12'd7, '0, '0);
    send_run(2, 1'b0);
    settle();

    first = 1'b1;
    while (steps_sent < STEP_TARGET) begin
      w = pick_size();
      h = pick_size();
      set_box(first ? 6'b11_1111 : 6'(($urandom() & 6'h3F) | 6'b00_1100),
              pick_origin(), pick_origin(), w, h, pick_radius(), $urandom());
      first = 1'b0;
      area = int'(w) * int'(h);
      if (area == 0)
        n = $urandom_range(2, 6);
      else if (area <= 200)
        n = area * $urandom_range(1, 2) + $urandom_range(0, 3);
      else
        n = $urandom_range(20, 60);
      if (n > STEP_TARGET - steps_sent)
        n = STEP_TARGET - steps_sent;
      send_run(n, $urandom_range(0, 3) != 0);
      settle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random stall before each pixel is taken
  initial begin
    int gap;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_chan.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
